>>> rtl/core/rau_pkg.sv
// Package: shared constants, types and operation codes of the rational arithmetic unit.
package rau_pkg;

	localparam int unsigned OperandWidthDefault = 16;
	localparam int unsigned QueueDepthDefault   = 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD_SHIFT,
		ST_GCD_LOOP,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_DONE
	} exec_state_t;

	// Flags decided by the front part for one transaction.
	typedef struct packed {
		logic bypass;
		logic equal;
		logic div_zero;
		logic bad_den;
		logic neg;
	} cls_flags_t;

endpackage

>>> rtl/core/rational_arithmetic_unit_core.sv
// Top level: rational arithmetic unit with GCD reduction.
// Usage:
//  Input channel is a queue write port: drive mode and the four fraction
//  fields with push; the transaction is taken on a clock edge with push high
//  and full low.
//  Result channel is a queue read port: while empty is low the result
//  (res_num/res_den reduced, sign in res_num, plus equal, div_zero, bad_den)
//  is on the ports; pop with empty low takes it.
//  Structure: two front stages form the four cross products (one multiplier
//  stage), then a two-entry queue, then the back sequencer: binary GCD
//  (one shift or subtract a cycle) and two restoring divisions.
//  The back part takes a new transaction only when it is idle and its
//  result register has been popped; bypassed cases (zero denominator,
//  divide by zero, zero numerator, compare) skip the GCD loop and the
//  divider.
//  Reset clears all valid state; queue and result register are empty.
//  When the receiver stalls, the held result blocks the back part, the queue
//  fills, then full rises; nothing is dropped.
module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [2:0]                      mode,
	input  logic signed [OPERAND_WIDTH-1:0] left_num,
	input  logic signed [OPERAND_WIDTH-1:0] left_den,
	input  logic signed [OPERAND_WIDTH-1:0] right_num,
	input  logic signed [OPERAND_WIDTH-1:0] right_den,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [2*OPERAND_WIDTH:0] res_num,
	output logic [2*OPERAND_WIDTH-2:0]      res_den,
	output logic                            equal,
	output logic                            div_zero,
	output logic                            bad_den
);
	localparam int unsigned NW = 2 * OPERAND_WIDTH + 1;
	localparam int unsigned DW = 2 * OPERAND_WIDTH;
	localparam int unsigned QW = NW + DW + $bits(cls_flags_t);

	logic          f_ready, f_valid, q_ready, q_valid, b_ready;
	logic [NW-1:0] f_n, q_n;
	logic [DW-1:0] f_d, q_d;
	cls_flags_t    f_fl, q_fl;
	logic [QW-1:0] q_rd;

	assign full = !f_ready;

	rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready(f_ready),
		.mode, .left_num, .left_den, .right_num, .right_den,
		.out_valid(f_valid), .out_ready(q_ready),
		.out_mag_n(f_n), .out_mag_d(f_d), .out_flags(f_fl)
	);

	rau_queue #(.WIDTH(QW), .DEPTH(QueueDepthDefault)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(q_ready), .wr_data({f_n, f_d, f_fl}),
		.rd_valid(q_valid), .rd_ready(b_ready), .rd_data(q_rd)
	);
	assign {q_n, q_d, q_fl} = q_rd;

	rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(b_ready),
		.in_mag_n(q_n), .in_mag_d(q_d), .in_flags(q_fl),
		.empty, .pop, .res_num, .res_den, .equal, .div_zero, .bad_den
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(res_num) && $stable(res_den))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> res_den != '0)
		else $error("zero result denominator");
endmodule

>>> rtl/core/rau_front.sv
// Front part: accept a transaction, form the cross products and classify it.
module rau_front import rau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     mode,
	input  logic signed [OPERAND_WIDTH-1:0] left_num,
	input  logic signed [OPERAND_WIDTH-1:0] left_den,
	input  logic signed [OPERAND_WIDTH-1:0] right_num,
	input  logic signed [OPERAND_WIDTH-1:0] right_den,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2*OPERAND_WIDTH:0]       out_mag_n,
	output logic [2*OPERAND_WIDTH-1:0]     out_mag_d,
	output cls_flags_t                     out_flags
);
	localparam int unsigned PW = 2 * OPERAND_WIDTH;

	// Stage 1: registered inputs; stage 2: products.
	logic                          v_s1, v_s2;
	logic [2:0]                    mode_s1, mode_s2;
	logic signed [OPERAND_WIDTH-1:0] ln_s1, ld_s1, rn_s1, rd_s1;
	logic signed [PW-1:0]          p_a_s2, p_b_s2, p_c_s2, p_d_s2;
	logic                          bad_s2, dz_s2;

	logic adv_s2, adv_s1;
	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			mode_s1 <= mode;
			ln_s1 <= left_num;
			ld_s1 <= left_den;
			rn_s1 <= right_num;
			rd_s1 <= right_den;
		end
		if (adv_s2 && v_s1) begin
			mode_s2 <= mode_s1;
			bad_s2  <= (ld_s1 == '0) || (rd_s1 == '0);
			dz_s2   <= (mode_s1 == OP_DIV) && (rn_s1 == '0);
			// ln*rd, ld*rn, ln*rn, ld*rd
			p_a_s2 <= PW'(ln_s1) * PW'(rd_s1);
			p_b_s2 <= PW'(ld_s1) * PW'(rn_s1);
			p_c_s2 <= PW'(ln_s1) * PW'(rn_s1);
			p_d_s2 <= PW'(ld_s1) * PW'(rd_s1);
		end
	end

	// Classification from the products.
	logic signed [PW:0] n_raw, d_raw;
	logic                valid_op;
	always_comb begin
		n_raw = '0;
		d_raw = (PW+1)'(1);
		valid_op = 1'b1;
		case (mode_s2)
			OP_ADD: begin
				n_raw = {p_a_s2[PW-1], p_a_s2} + {p_b_s2[PW-1], p_b_s2};
				d_raw = {p_d_s2[PW-1], p_d_s2};
			end
			OP_SUB: begin
				n_raw = {p_a_s2[PW-1], p_a_s2} - {p_b_s2[PW-1], p_b_s2};
				d_raw = {p_d_s2[PW-1], p_d_s2};
			end
			OP_MUL: begin
				n_raw = {p_c_s2[PW-1], p_c_s2};
				d_raw = {p_d_s2[PW-1], p_d_s2};
			end
			OP_DIV: begin
				n_raw = {p_a_s2[PW-1], p_a_s2};
				d_raw = {p_b_s2[PW-1], p_b_s2};
			end
			default: valid_op = 1'b0;
		endcase
	end

	logic [PW:0] n_abs, d_abs;
	assign n_abs = n_raw[PW] ? (PW+1)'(-n_raw) : n_raw;
	assign d_abs = d_raw[PW] ? (PW+1)'(-d_raw) : d_raw;

	assign out_valid = v_s2;
	assign out_mag_n = n_abs;
	assign out_mag_d = d_abs[PW-1:0];
	always_comb begin
		out_flags.bad_den  = bad_s2;
		out_flags.div_zero = dz_s2;
		out_flags.equal    = !bad_s2 && (mode_s2 == OP_CMP) && (p_a_s2 == p_b_s2);
		out_flags.bypass   = bad_s2 || dz_s2 || !valid_op || (n_raw == '0);
		out_flags.neg      = n_raw[PW] ^ d_raw[PW];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_flags.div_zero |-> out_flags.bypass)
		else $error("divide by zero not bypassed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_flags.bad_den |-> !out_flags.equal)
		else $error("equal set with zero denominator");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(p_a_s2))
		else $error("stalled product lost");
endmodule

>>> rtl/core/rau_queue.sv
// Short queue between the front and back parts.
module rau_queue import rau_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             wr_en, rd_en;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("queue overflow");
endmodule

>>> rtl/core/rau_back.sv
// Back part: binary GCD, two restoring divisions and the result register.
module rau_back import rau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2*OPERAND_WIDTH:0]   in_mag_n,
	input  logic [2*OPERAND_WIDTH-1:0] in_mag_d,
	input  cls_flags_t                 in_flags,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [2*OPERAND_WIDTH:0] res_num,
	output logic [2*OPERAND_WIDTH-2:0] res_den,
	output logic                       equal,
	output logic                       div_zero,
	output logic                       bad_den
);
	localparam int unsigned W  = 2 * OPERAND_WIDTH + 1;
	localparam int unsigned CW = $clog2(W + 1);

	exec_state_t st_q, st_d;
	logic [W-1:0]   a_q, b_q, n_q, d_q, quo_q, rem_q, g_q;
	logic [CW-1:0]  k_q, i_q;
	cls_flags_t     fl_q;
	logic           full_q;

	// Division step over the current remainder.
	logic [W-1:0] div_src, rem_sh;
	logic         fit;
	assign div_src = (st_q == ST_DIV_NUM) ? n_q : d_q;
	assign rem_sh  = {rem_q[W-2:0], div_src[i_q]};
	assign fit     = (rem_sh >= g_q);

	assign in_ready = (st_q == ST_IDLE) && !full_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:      if (in_valid && !full_q) st_d = in_flags.bypass ? ST_DONE : ST_GCD_SHIFT;
			ST_GCD_SHIFT: if (a_q[0] || b_q[0]) st_d = ST_GCD_LOOP;
			ST_GCD_LOOP:  if (!a_q[0] && b_q != '0) st_d = ST_GCD_LOOP;
			              else if (b_q == '0) st_d = ST_DIV_NUM;
			ST_DIV_NUM:   if (i_q == '0) st_d = ST_DIV_DEN;
			ST_DIV_DEN:   if (i_q == '0) st_d = ST_DONE;
			ST_DONE:      st_d = ST_IDLE;
			default:      st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			full_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DONE) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_valid && !full_q) begin
				fl_q <= in_flags;
				n_q <= in_mag_n;
				d_q <= W'(in_mag_d);
				a_q <= in_mag_n;
				b_q <= W'(in_mag_d);
				k_q <= '0;
				quo_q <= '0;
			end
			ST_GCD_SHIFT: if (!(a_q[0] || b_q[0])) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end
			ST_GCD_LOOP: begin
				// a kept odd; strip b, then subtract the smaller.
				if (!a_q[0]) a_q <= a_q >> 1;
				else if (b_q == '0) begin
					g_q <= a_q << k_q;
					i_q <= CW'(W - 1);
					rem_q <= '0;
				end else if (!b_q[0]) b_q <= b_q >> 1;
				else if (a_q > b_q) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else b_q <= b_q - a_q;
			end
			ST_DIV_NUM, ST_DIV_DEN: begin
				quo_q <= {quo_q[W-2:0], fit};
				if (i_q == '0) begin
					i_q <= CW'(W - 1);
					rem_q <= '0;
					if (st_q == ST_DIV_NUM) n_q <= {quo_q[W-2:0], fit};
					else d_q <= {quo_q[W-2:0], fit};
				end else begin
					i_q <= i_q - 1'b1;
					rem_q <= fit ? rem_sh - g_q : rem_sh;
				end
			end
			ST_DONE: begin
				equal <= fl_q.equal;
				div_zero <= fl_q.div_zero;
				bad_den <= fl_q.bad_den;
				if (fl_q.bypass) begin
					res_num <= '0;
					res_den <= (W-2)'(1);
				end else begin
					res_num <= fl_q.neg ? W'(-n_q) : n_q;
					res_den <= d_q[W-3:0];
				end
			end
			default: ;
		endcase
	end

	assign empty = !full_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DONE |-> !full_q)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DONE |=> !empty)
		else $error("result not posted");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV_NUM |-> g_q != '0)
		else $error("zero divisor");
endmodule
